// File: design/assert_macros.svh
// assertion macros shared by the tokeniser rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dtok_pkg.sv
// types and constants for the delimiter tokeniser
// no dependencies
package dtok_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic REG_DELIMITER  = 1'b0;
    localparam logic REG_MAX_TOKENS = 1'b1;

    localparam logic [7:0] DELIMITER_RESET  = 8'd32;
    localparam logic [4:0] MAX_TOKENS_RESET = 5'd16;

    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int COUNT_W = 5;
    localparam int POS_W   = 11;

    typedef struct packed {
        kind_t                kind;
        logic [START_W-1:0]   token_start;
        logic [LEN_W-1:0]     token_len;
        logic [COUNT_W-1:0]   token_count;
        logic [POS_W-1:0]     last_pos;
        logic                 last_pos_valid;
        logic                 end_of_run;
    } res_t;

endpackage

// File: design/delimiter_tokenizer_core.sv
// delimiter tokeniser: splits a character stream into tokens, reports done or error
// depends on dtok_pkg and assert_macros.svh
//
// an accepted word is held in the input register, then processed into a four-entry
// result queue once it has room for two results; the queue head drives the master side
// throughput: one character per cycle while the queue has room for two results; a
// character that gives a token and the done result offers them one after the other
// on the master side, set by the single queue read port
// reset (synchronous, active low): string state and queue cleared, delimiter = 32,
// max_tokens = 16
`include "assert_macros.svh"

module delimiter_tokenizer_core #(
    parameter int MAX_LEN    = 1024,
    parameter int MAX_TOKENS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // ch[7:0]
    input  logic        s_tlast,    // last character of the string
    input  logic        s_tuser,    // empty_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // token_start[9:0], token_len[20:10], token_count[25:21],
                                    // last_pos[36:26], last_pos_valid[37], zero[39:38]
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast     // end_of_run
);

    // position counter must hold MAX_LEN itself
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam logic [QCW-1:0] Q_ROOM2 = QCW'(QDEPTH - 2);

    // configuration registers
    logic [7:0]                   delimiter_reg;
    logic [dtok_pkg::COUNT_W-1:0] max_tokens_reg;
    logic [dtok_pkg::COUNT_W-1:0] cap;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // string state
    logic [PW-1:0]                position_reg, position_next;
    logic [PW-1:0]                token_begin_reg, token_begin_next;
    logic [dtok_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PW-1:0]                last_seen_reg, last_seen_next;
    logic                         last_seen_valid_reg, last_seen_valid_next;

    // processing stage scratch
    logic                         adv;
    logic [PW-1:0]                pos_inc;
    logic                         hit;
    logic                         tok_first;
    logic                         tok_final;
    logic [PW-1:0]                tb_after;
    logic [dtok_pkg::COUNT_W-1:0] cnt_after;
    logic [PW-1:0]                ls_after;
    logic                         lsv_after;
    logic [1:0]                   nres;
    dtok_pkg::res_t               res0, res1;

    // result queue
    dtok_pkg::res_t   q_mem [QDEPTH];
    logic [QAW-1:0]   q_wr_reg, q_wr_next;
    logic [QAW-1:0]   q_rd_reg, q_rd_next;
    logic [QCW-1:0]   q_cnt_reg, q_cnt_next;
    logic             pop;
    dtok_pkg::res_t   q_head;

    // values above the build-time cap act as the cap
    assign cap = (32'(max_tokens_reg) > MAX_TOKENS) ? dtok_pkg::COUNT_W'(MAX_TOKENS)
                                                    : max_tokens_reg;

    // the stage fires only when the queue can take a full pair of results
    assign adv      = in_valid_reg && (q_cnt_reg <= Q_ROOM2);
    assign s_tready = !in_valid_reg || adv;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg  <= dtok_pkg::DELIMITER_RESET;
            max_tokens_reg <= dtok_pkg::MAX_TOKENS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                dtok_pkg::REG_DELIMITER:  delimiter_reg  <= cfg_wdata;
                dtok_pkg::REG_MAX_TOKENS: max_tokens_reg <= cfg_wdata[dtok_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, refilled whenever it empties or moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg    <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    // single-pass processing of the held character
    always_comb begin
        pos_inc              = position_reg + ONE_P;
        hit                  = (count_reg < cap) && (in_ch_reg == delimiter_reg);
        tok_first            = hit && (position_reg != token_begin_reg);
        tb_after             = hit ? pos_inc : token_begin_reg;
        cnt_after            = count_reg + dtok_pkg::COUNT_W'(tok_first);
        ls_after             = hit ? position_reg : last_seen_reg;
        lsv_after            = hit || last_seen_valid_reg;
        // final token runs from the candidate start through the last character
        tok_final            = (cnt_after < cap) && (tb_after < pos_inc);

        position_next        = position_reg;
        token_begin_next     = token_begin_reg;
        count_next           = count_reg;
        last_seen_next       = last_seen_reg;
        last_seen_valid_next = last_seen_valid_reg;
        nres                 = 2'd0;
        res0                 = '0;
        res1                 = '0;

        if (adv) begin
            if (in_empty_reg || (32'(position_reg) >= MAX_LEN)) begin
                // empty string, or the closing word of an overlong one
                if (in_empty_reg || in_last_reg) begin
                    nres            = 2'd1;
                    res0.kind       = dtok_pkg::KIND_ERROR;
                    res0.end_of_run = 1'b1;
                    position_next        = '0;
                    token_begin_next     = '0;
                    count_next           = '0;
                    last_seen_next       = '0;
                    last_seen_valid_next = 1'b0;
                end
            end else if (!in_last_reg) begin
                position_next        = pos_inc;
                token_begin_next     = tb_after;
                count_next           = cnt_after;
                last_seen_next       = ls_after;
                last_seen_valid_next = lsv_after;
                if (tok_first) begin
                    nres              = 2'd1;
                    res0.kind         = dtok_pkg::KIND_TOKEN;
                    res0.token_start  = dtok_pkg::START_W'(token_begin_reg);
                    res0.token_len    = dtok_pkg::LEN_W'(position_reg - token_begin_reg);
                    res0.end_of_run   = 1'b1;
                end
            end else begin
                // last character: optional token, then done
                res1.kind           = dtok_pkg::KIND_DONE;
                res1.end_of_run     = 1'b1;
                res1.last_pos_valid = lsv_after || tok_final;
                if (tok_first) begin
                    nres               = 2'd2;
                    res0.kind          = dtok_pkg::KIND_TOKEN;
                    res0.token_start   = dtok_pkg::START_W'(token_begin_reg);
                    res0.token_len     = dtok_pkg::LEN_W'(position_reg - token_begin_reg);
                    res1.token_count   = cnt_after;
                    res1.last_pos      = dtok_pkg::POS_W'(ls_after);
                end else if (tok_final) begin
                    nres               = 2'd2;
                    res0.kind          = dtok_pkg::KIND_TOKEN;
                    res0.token_start   = dtok_pkg::START_W'(tb_after);
                    res0.token_len     = dtok_pkg::LEN_W'(pos_inc - tb_after);
                    res1.token_count   = cnt_after + dtok_pkg::COUNT_W'(1);
                    res1.last_pos      = dtok_pkg::POS_W'(pos_inc);
                end else begin
                    nres               = 2'd1;
                    res1.token_count   = cnt_after;
                    res1.last_pos      = lsv_after ? dtok_pkg::POS_W'(ls_after) : '0;
                end
                if (nres == 2'd1) begin
                    res0 = res1;
                end else begin
                    res0.end_of_run = 1'b0;
                end
                position_next        = '0;
                token_begin_next     = '0;
                count_next           = '0;
                last_seen_next       = '0;
                last_seen_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg        <= '0;
            token_begin_reg     <= '0;
            count_reg           <= '0;
            last_seen_reg       <= '0;
            last_seen_valid_reg <= 1'b0;
        end else begin
            position_reg        <= position_next;
            token_begin_reg     <= token_begin_next;
            count_reg           <= count_next;
            last_seen_reg       <= last_seen_next;
            last_seen_valid_reg <= last_seen_valid_next;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    assign pop        = m_tvalid && m_tready;
    assign q_wr_next  = q_wr_reg + QAW'(nres);
    assign q_rd_next  = q_rd_reg + QAW'(pop);
    assign q_cnt_next = q_cnt_reg + QCW'(nres) - QCW'(pop);

    always_ff @(posedge aclk) begin
        if (nres != 2'd0) begin
            q_mem[q_wr_reg] <= res0;
        end
        if (nres == 2'd2) begin
            q_mem[q_wr_reg + QAW'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    // head of the queue drives the master side
    assign q_head   = q_mem[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.end_of_run;
    assign m_tdata  = {2'b00, q_head.last_pos_valid, q_head.last_pos, q_head.token_count,
                       q_head.token_len, q_head.token_start};

    // checks
    `ASSERT_HOLDS(a_q_bound, q_cnt_reg <= QCW'(QDEPTH), "result queue overfilled")
    `ASSERT_HOLDS(a_end_words_close_run,
                  !m_tvalid || m_tuser == dtok_pkg::KIND_TOKEN || m_tlast,
                  "done or error word without end of run")
    `ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, in_valid_reg,
                 "accepted word not held in input register")
    `ASSERT_HOLDS(a_count_capped, count_reg <= cap || !in_valid_reg || cfg_we,
                  "token count beyond cap")

endmodule

// File: test/testbench.sv
// self-checking testbench for delimiter_tokenizer_core: directed, register, long and random strings
// depends on dtok_pkg and the core rtl, holds its own model of the tokeniser
module testbench;

    localparam int STR_MAX      = 1024;      // longest string the block takes
    localparam int TOKEN_CAP    = 16;        // hard token cap of the block
    localparam int SETTLE       = 8;         // cycles for a word with no result to clear the core
    localparam int CYCLE_LIMIT  = 2000000;   // watchdog, far above the slowest legal run
    localparam int RANDOM_WORDS = 150;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // ch[7:0]
    logic        s_tlast;     // last character of the string
    logic        s_tuser;     // empty_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;     // token_start[9:0], token_len[20:10], token_count[25:21],
                              // last_pos[36:26], last_pos_valid[37], zero[39:38]
    logic [1:0]  m_tuser;     // kind
    logic        m_tlast;     // end_of_run

    delimiter_tokenizer_core #(
        .MAX_LEN    (STR_MAX),
        .MAX_TOKENS (TOKEN_CAP)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // model copy of the registers
    logic [7:0]  delim_reg;
    logic [4:0]  cap_reg;

    // model copy of the per-string state
    logic [10:0] str_pos;
    logic [10:0] tok_begin;
    logic [4:0]  tok_count;
    logic [10:0] last_delim;
    logic        last_delim_valid;

    // results predicted but not yet seen on the master side, oldest first
    dtok_pkg::res_t awaited[$];

    int          fail_count   = 0;
    int          words_sent   = 0;
    int          reg_writes   = 0;
    int          tokens_seen  = 0;
    int          done_seen    = 0;
    int          errors_seen  = 0;
    int          cycle_count  = 0;

    // idling control: quiet stretches turn every gap and stall off
    logic        quiet = 1'b0;
    int          quiet_left = 300;
    int          stall_left = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // idling
    // ---------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // switch between busy and calm stretches; nonblocking so readers see one value per edge
    always @(posedge aclk) begin
        if (quiet_left == 0) begin
            quiet      <= ~quiet;
            quiet_left  = quiet ? $urandom_range(200, 800) : $urandom_range(50, 200);
        end else begin
            quiet_left--;
        end
    end

    // receiver back-pressure, changed at the falling edge
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready   <= 1'b1;
            stall_left  = idle_cycles();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tokeniser model
    // ---------------------------------------------------------------

    function automatic dtok_pkg::res_t make_result(dtok_pkg::kind_t kind, logic [9:0] start,
                                                   logic [10:0] len, logic [4:0] cnt,
                                                   logic [10:0] pos, logic pos_ok);
        dtok_pkg::res_t r;
        r.kind           = kind;
        r.token_start    = start;
        r.token_len      = len;
        r.token_count    = cnt;
        r.last_pos       = pos;
        r.last_pos_valid = pos_ok;
        r.end_of_run     = 1'b0;
        return r;
    endfunction

    task automatic clear_string();
        str_pos          = '0;
        tok_begin        = '0;
        tok_count        = '0;
        last_delim       = '0;
        last_delim_valid = 1'b0;
    endtask

    // advance the model by one accepted word and queue the results it gives
    task automatic tokenise_word(input logic [7:0] ch, input logic last, input logic empty);
        dtok_pkg::res_t outs[$];
        dtok_pkg::res_t r;
        logic [4:0]     cap;
        logic [10:0]    p;
        // register values above the hard cap act as the hard cap
        cap = (cap_reg > TOKEN_CAP) ? 5'(TOKEN_CAP) : cap_reg;
        if (empty) begin
            // empty string: one error, any string in progress is dropped
            outs.push_back(make_result(dtok_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0));
            clear_string();
        end else if (str_pos >= STR_MAX) begin
            // overlong: characters are swallowed until the last one, which gives the error
            if (last) begin
                outs.push_back(make_result(dtok_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0));
                clear_string();
            end
        end else begin
            p = str_pos;
            if (tok_count < cap && ch == delim_reg) begin
                // runs of delimiters give no empty tokens
                if (p != tok_begin) begin
                    outs.push_back(make_result(dtok_pkg::KIND_TOKEN, tok_begin[9:0],
                                               p - tok_begin, '0, '0, 1'b0));
                    tok_count++;
                end
                last_delim       = p;
                last_delim_valid = 1'b1;
                tok_begin        = p + 11'd1;
            end
            if (!last) begin
                str_pos = p + 11'd1;
            end else begin
                // a final token runs up to the end of the string
                if (tok_count < cap && tok_begin < p + 11'd1) begin
                    outs.push_back(make_result(dtok_pkg::KIND_TOKEN, tok_begin[9:0],
                                               p + 11'd1 - tok_begin, '0, '0, 1'b0));
                    tok_count++;
                    last_delim       = p + 11'd1;
                    last_delim_valid = 1'b1;
                end
                outs.push_back(make_result(dtok_pkg::KIND_DONE, '0, '0, tok_count,
                                           last_delim_valid ? last_delim : 11'd0,
                                           last_delim_valid));
                clear_string();
            end
        end
        foreach (outs[i]) begin
            r            = outs[i];
            r.end_of_run = (i == outs.size() - 1);
            awaited.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic note_fault(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
            note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge aclk) begin : result_check
        dtok_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                note_fault($sformatf("result with nothing awaited: kind %0d data %h last %b",
                                     m_tuser, m_tdata, m_tlast));
            end else begin
                want = awaited.pop_front();
                compare_field("kind",           32'(want.kind),           32'(m_tuser));
                compare_field("token_start",    32'(want.token_start),    32'(m_tdata[9:0]));
                compare_field("token_len",      32'(want.token_len),      32'(m_tdata[20:10]));
                compare_field("token_count",    32'(want.token_count),    32'(m_tdata[25:21]));
                compare_field("last_pos",       32'(want.last_pos),       32'(m_tdata[36:26]));
                compare_field("last_pos_valid", 32'(want.last_pos_valid), 32'(m_tdata[37]));
                compare_field("padding",        0,                        32'(m_tdata[39:38]));
                compare_field("end_of_run",     32'(want.end_of_run),     32'(m_tlast));
                case (want.kind)
                    dtok_pkg::KIND_TOKEN: tokens_seen++;
                    dtok_pkg::KIND_DONE:  done_seen++;
                    default:              errors_seen++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one character word, after a random gap; the model steps at acceptance
    task automatic send_word(input logic [7:0] ch, input logic last, input logic empty);
        int gap;
        gap = idle_cycles();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        s_tuser  <= empty;
        do @(posedge aclk); while (!s_tready);
        tokenise_word(ch, last, empty);
        words_sent++;
    endtask

    // stop sending and let every awaited result drain, plus a margin for silent words
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // only called with the core idle
    task automatic write_reg(input logic addr, input logic [7:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (addr == dtok_pkg::REG_DELIMITER)
            delim_reg = data;
        else
            cap_reg = data[4:0];
        reg_writes++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(txt[i], i == txt.len() - 1, 1'b0);
    endtask

    // random string: delimiters at the given rate per thousand; it may break off with an
    // empty request at the given rate, or, when abandon is set, always ends with one
    task automatic send_string(input int len, input int delim_pm, input int break_pm,
                               input bit abandon);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 999) < break_pm) begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
            // occasional full pause mid-string
            if (break_pm > 0 && $urandom_range(0, 999) < 8) wait_idle();
            if ($urandom_range(0, 999) < delim_pm) begin
                ch = delim_reg;
            end else begin
                ch = 8'($urandom_range(0, 255));
                if (ch == delim_reg) ch = ch ^ 8'h01;
            end
            send_word(ch, !abandon && i == len - 1, 1'b0);
        end
        if (abandon) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset delimiter (space) and cap
    task automatic test_directed_strings();
        send_text("  ab  c ");            // leading run, inner run, closing delimiter last
        send_text("x");                   // single character token
        send_text(" ");                   // only a delimiter: no token, position 0
        send_word(8'h41, 1'b1, 1'b1);     // empty string on its own
        send_word("q", 1'b0, 1'b0);       // string dropped by an empty request
        send_word("r", 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);     // character code extremes
        send_word(8'hFF, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // zero cap: no tokens, no delimiter position
        write_reg(dtok_pkg::REG_DELIMITER, 8'h00);
        write_reg(dtok_pkg::REG_MAX_TOKENS, 8'd0);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h02, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        wait_idle();
        // cap of one with the top delimiter code: later characters ignored
        write_reg(dtok_pkg::REG_DELIMITER, 8'hFF);
        write_reg(dtok_pkg::REG_MAX_TOKENS, 8'd1);
        send_word("a", 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word("b", 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word("c", 1'b1, 1'b0);
        wait_idle();
        // cap register above the hard cap, upper data bits set
        write_reg(dtok_pkg::REG_DELIMITER, ",");
        write_reg(dtok_pkg::REG_MAX_TOKENS, {3'b101, 5'd31});
        for (int i = 0; i < 20; i++) send_text("a,");
        send_text("z");
        wait_idle();
        write_reg(dtok_pkg::REG_DELIMITER, dtok_pkg::DELIMITER_RESET);
        write_reg(dtok_pkg::REG_MAX_TOKENS, {3'b000, dtok_pkg::MAX_TOKENS_RESET});
        wait_idle();
    endtask

    // a string beyond the length limit
    task automatic test_long_strings();
        send_string(STR_MAX + 3, 15, 0, 1'b0);    // tokens over the whole range, ignored tail
        send_text("ok go");                       // state must be clean again
        wait_idle();
    endtask

    task automatic test_random_strings();
        int   target;
        int   phase_end;
        int   r;
        int   len;
        logic [4:0] cap;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            // new register setting for each phase, written with the core idle
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(dtok_pkg::REG_DELIMITER, 8'h20);
                1:       write_reg(dtok_pkg::REG_DELIMITER, 8'h00);
                2:       write_reg(dtok_pkg::REG_DELIMITER, 8'hFF);
                default: write_reg(dtok_pkg::REG_DELIMITER, 8'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 5))
                0:       cap = 5'd0;
                1:       cap = 5'd1;
                2:       cap = 5'd16;
                3:       cap = 5'd31;
                default: cap = 5'($urandom_range(2, 6));
            endcase
            write_reg(dtok_pkg::REG_MAX_TOKENS, {3'($urandom_range(0, 7)), cap});
            phase_end = words_sent + $urandom_range(30, 60);
            while (words_sent < phase_end && words_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 80)      len = $urandom_range(1, 12);
                else if (r < 96) len = $urandom_range(13, 40);
                else             len = $urandom_range(60, 150);
                send_string(len, 350, 15, 1'b0);
            end
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = dtok_pkg::REG_DELIMITER;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        delim_reg = dtok_pkg::DELIMITER_RESET;
        cap_reg   = dtok_pkg::MAX_TOKENS_RESET;
        clear_string();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_strings();
        test_register_extremes();
        test_long_strings();
        test_random_strings();

        wait_idle();
        fail_count += awaited.size();
        $display("covered %0d characters and %0d register writes, delimiter and cap extremes",
                 words_sent, reg_writes);
        $display("checked %0d tokens, %0d done and %0d error results, %0d faults",
                 tokens_seen, done_seen, errors_seen, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/dtok_pkg.sv
design/delimiter_tokenizer_core.sv
test/testbench.sv
